>>> rtl/toeq_pkg.sv
// Shared types and constants for the time-ordered event queue.
package toeq_pkg;

	localparam int unsigned QueueDepthDefault = 16;
	localparam int unsigned TimeW = 32;
	localparam int unsigned JobW = 16;
	localparam int unsigned KindW = 3;
	localparam int unsigned DiskW = 2;
	localparam int unsigned OccW = 5;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [TimeW-1:0] ev_time;
		logic [JobW-1:0] job;
		logic [KindW-1:0] kind;
		logic [DiskW-1:0] disk;
	} entry_t;

	// Per-beat control handed to every cell.
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

>>> rtl/toeq_ifs.sv
// Handshake channel interfaces for command and result beats.
interface toeq_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [toeq_pkg::TimeW-1:0] event_time;
	logic [toeq_pkg::JobW-1:0] job_id;
	logic [toeq_pkg::KindW-1:0] event_kind;
	logic [toeq_pkg::DiskW-1:0] disk_id;

	modport source (output valid, cmd, event_time, job_id, event_kind, disk_id, input ready);
	modport sink (input valid, cmd, event_time, job_id, event_kind, disk_id, output ready);
endinterface

interface toeq_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [toeq_pkg::TimeW-1:0] out_time;
	logic [toeq_pkg::JobW-1:0] out_job;
	logic [toeq_pkg::KindW-1:0] out_kind;
	logic [toeq_pkg::DiskW-1:0] out_disk;
	logic [toeq_pkg::OccW-1:0] occupancy;

	modport source (output valid, status, out_time, out_job, out_kind, out_disk, occupancy,
		input ready);
	modport sink (input valid, status, out_time, out_job, out_kind, out_disk, occupancy,
		output ready);
endinterface

>>> rtl/time_ordered_event_queue_core.sv
// Top level: sorted event queue built as a shifting row of slot cells.
//
//   channel | dir | beat
//   in      | in  | cmd, event_time, job_id, event_kind, disk_id
//   out     | out | status, out_time, out_job, out_kind, out_disk, occupancy
//
// For each command beat, all cells compare against the new
// key in parallel and shift or load together; the result is registered.
// Throughput is one beat per cycle while out accepts; a held result stalls in.
// Reset clears the count and the result valid; slot contents need no reset.
module time_ordered_event_queue_core #(
	parameter int unsigned QUEUE_DEPTH = toeq_pkg::QueueDepthDefault
) (
	input logic      clk,
	input logic      arst_n,
	toeq_in_if.sink  in,
	toeq_out_if.source out
);

	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

	logic [CntW-1:0] count_q;
	logic [CntW-1:0] count_d;
	logic            accept;
	logic            is_rem;
	logic            empty;
	logic            full;
	toeq_pkg::cell_ctl_t ctl;
	toeq_pkg::entry_t    new_entry;
	toeq_pkg::entry_t    cell_entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] later;
	logic [QUEUE_DEPTH-1:0] occupied;

	logic                 out_valid_q;
	toeq_pkg::status_t    status_q;
	toeq_pkg::entry_t     res_q;
	logic [toeq_pkg::OccW-1:0] occ_q;
	toeq_pkg::status_t    status_d;
	toeq_pkg::entry_t     res_d;

	assign in.ready = !out_valid_q || out.ready;
	assign accept = in.valid && in.ready;
	assign is_rem = (toeq_pkg::cmd_t'(in.cmd) == toeq_pkg::CMD_REMOVE);
	assign empty = (count_q == '0);
	assign full = (count_q == CntW'(QUEUE_DEPTH));

	assign new_entry = '{ev_time: in.event_time, job: in.job_id, kind: in.event_kind,
		disk: in.disk_id};

	assign ctl.ins = accept && !is_rem && !full;
	assign ctl.rem = accept && is_rem && !empty;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		toeq_pkg::entry_t nxt;
		logic             prv_later;

		assign occupied[i] = (CntW'(i) < count_q);
		if (i == 0) begin : g_head
			assign prv_later = 1'b0;
		end else begin : g_body
			assign prv_later = later[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign nxt = cell_entry[i];
		end else begin : g_mid
			assign nxt = cell_entry[i+1];
		end

		toeq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (occupied[i]),
			.prev_later (prv_later),
			.new_entry  (new_entry),
			.prev_entry (i == 0 ? new_entry : cell_entry[(i == 0) ? 0 : i-1]),
			.next_entry (nxt),
			.later      (later[i]),
			.entry      (cell_entry[i])
		);
	end

	always_comb begin
		count_d = count_q;
		status_d = toeq_pkg::ST_OK;
		res_d = '0;
		if (is_rem) begin
			if (empty) begin
				status_d = toeq_pkg::ST_EMPTY;
			end else begin
				res_d = cell_entry[0];
				count_d = count_q - CntW'(1);
			end
		end else begin
			if (full) begin
				status_d = toeq_pkg::ST_FULL;
			end else begin
				count_d = count_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			res_q <= res_d;
			occ_q <= toeq_pkg::OccW'(count_d);
		end
	end

	assign out.valid = out_valid_q;
	assign out.status = status_q;
	assign out.out_time = res_q.ev_time;
	assign out.out_job = res_q.job;
	assign out.out_kind = res_q.kind;
	assign out.out_disk = res_q.disk;
	assign out.occupancy = occ_q;

endmodule

>>> rtl/toeq_cell.sv
// One queue slot: compares against the new key and shifts with its neighbours.
module toeq_cell (
	input  logic                clk,
	input  toeq_pkg::cell_ctl_t ctl,
	input  logic                occupied,
	input  logic                prev_later,
	input  toeq_pkg::entry_t    new_entry,
	input  toeq_pkg::entry_t    prev_entry,
	input  toeq_pkg::entry_t    next_entry,
	output logic                later,
	output toeq_pkg::entry_t    entry
);

	toeq_pkg::entry_t entry_q;
	toeq_pkg::entry_t entry_d;

	// Empty slots count as later so the new event lands at the tail.
	assign later = !occupied || (entry_q.ev_time > new_entry.ev_time);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (ctl.rem) begin
			entry_d = next_entry;
		end else if (ctl.ins && later) begin
			entry_d = prev_later ? prev_entry : new_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

>>> sim/tb_time_ordered_event_queue_core.sv
// Self-checking testbench for the time-ordered event queue core.
module tb_time_ordered_event_queue_core;

	localparam int unsigned QDepth = toeq_pkg::QueueDepthDefault;
	localparam int CycleLimit = 200000;
	localparam int RandomBeats = 550;
	localparam int CalmBeats = 60;

	typedef struct packed {
		toeq_pkg::status_t status;
		logic [toeq_pkg::TimeW-1:0] ev_time;
		logic [toeq_pkg::JobW-1:0] job;
		logic [toeq_pkg::KindW-1:0] kind;
		logic [toeq_pkg::DiskW-1:0] disk;
		logic [toeq_pkg::OccW-1:0] occupancy;
	} result_t;

	typedef struct packed {
		toeq_pkg::cmd_t cmd;
		toeq_pkg::entry_t ev;
		logic typed;
		result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	toeq_in_if cmd_ch ();
	toeq_out_if res_ch ();

	time_ordered_event_queue_core #(
		.QUEUE_DEPTH(QDepth)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(cmd_ch),
		.out(res_ch)
	);

	toeq_pkg::entry_t model_slots[$];
	result_t pending_results[$];
	stim_row_t directed_rows[$];

	int failures = 0;
	int cycle_cnt = 0;
	int beats_sent = 0;
	int dispatched = 0;
	int empty_removes = 0;
	int full_inserts = 0;
	logic calm = 1'b0;

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sorted store: insert behind every entry with time <= new time.
	function automatic result_t queue_model_step(toeq_pkg::cmd_t c, toeq_pkg::entry_t ev);
		result_t r;
		toeq_pkg::entry_t head;
		int n;
		int pos;
		bit found;
		r = '0;
		r.status = toeq_pkg::ST_OK;
		n = model_slots.size();
		if (c == toeq_pkg::CMD_REMOVE) begin
			if (n == 0) begin
				r.status = toeq_pkg::ST_EMPTY;
			end else begin
				head = model_slots.pop_front();
				r.ev_time = head.ev_time;
				r.job = head.job;
				r.kind = head.kind;
				r.disk = head.disk;
			end
		end else if (n >= QDepth) begin
			r.status = toeq_pkg::ST_FULL;
		end else begin
			pos = n;
			found = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (!found && model_slots[i].ev_time > ev.ev_time) begin
					pos = i;
					found = 1'b1;
				end
			end
			model_slots.push_back(ev);
			for (int i = n; i > pos; i--)
				model_slots[i] = model_slots[i-1];
			model_slots[pos] = ev;
		end
		n = model_slots.size();
		r.occupancy = n[toeq_pkg::OccW-1:0];
		return r;
	endfunction

	function automatic stim_row_t mk_row(toeq_pkg::cmd_t c, logic [toeq_pkg::TimeW-1:0] t,
			logic [toeq_pkg::JobW-1:0] j, logic [toeq_pkg::KindW-1:0] k,
			logic [toeq_pkg::DiskW-1:0] d, logic typed, toeq_pkg::status_t st,
			logic [toeq_pkg::TimeW-1:0] ot, logic [toeq_pkg::JobW-1:0] oj,
			logic [toeq_pkg::KindW-1:0] okind, logic [toeq_pkg::DiskW-1:0] od,
			logic [toeq_pkg::OccW-1:0] occ);
		stim_row_t row;
		row.cmd = c;
		row.ev.ev_time = t;
		row.ev.job = j;
		row.ev.kind = k;
		row.ev.disk = d;
		row.typed = typed;
		row.res.status = st;
		row.res.ev_time = ot;
		row.res.job = oj;
		row.res.kind = okind;
		row.res.disk = od;
		row.res.occupancy = occ;
		return row;
	endfunction

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic send_beat(toeq_pkg::cmd_t c, toeq_pkg::entry_t ev, logic typed,
			result_t typed_res);
		result_t predicted;
		cmd_ch.valid <= 1'b1;
		cmd_ch.cmd <= c;
		cmd_ch.event_time <= ev.ev_time;
		cmd_ch.job_id <= ev.job;
		cmd_ch.event_kind <= ev.kind;
		cmd_ch.disk_id <= ev.disk;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		predicted = queue_model_step(c, ev);
		case (predicted.status)
			toeq_pkg::ST_EMPTY: empty_removes++;
			toeq_pkg::ST_FULL: full_inserts++;
			default: if (c == toeq_pkg::CMD_REMOVE) dispatched++;
		endcase
		pending_results.push_back(typed ? typed_res : predicted);
		beats_sent++;
	endtask

	task automatic idle_gap();
		if (!calm && $urandom_range(0, 6) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain_pause();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (act !== exp) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			failures++;
		end
	endtask

	// Result side: random stall bursts, none once calm.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t exp;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: status %0d occupancy %0d",
					res_ch.status, res_ch.occupancy);
				failures++;
			end else begin
				exp = pending_results.pop_front();
				check_field("status", 32'(exp.status), 32'(res_ch.status));
				check_field("out_time", exp.ev_time, res_ch.out_time);
				check_field("out_job", 32'(exp.job), 32'(res_ch.out_job));
				check_field("out_kind", 32'(exp.kind), 32'(res_ch.out_kind));
				check_field("out_disk", 32'(exp.disk), 32'(res_ch.out_disk));
				check_field("occupancy", 32'(exp.occupancy), 32'(res_ch.occupancy));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		toeq_pkg::entry_t ev;
		toeq_pkg::cmd_t c;
		int ins_pct;
		int roll;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = toeq_pkg::CMD_INSERT;
		cmd_ch.event_time = '0;
		cmd_ch.job_id = '0;
		cmd_ch.event_kind = '0;
		cmd_ch.disk_id = '0;
		arst_n = 1'b0;

		// Extremes and the empty flag, then a fill with tied keys and the full flag.
		directed_rows.push_back(mk_row(toeq_pkg::CMD_REMOVE, 0, 0, 0, 0, 1,
			toeq_pkg::ST_EMPTY, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(toeq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 3'd7,
			2'd3, 1, toeq_pkg::ST_OK, 0, 0, 0, 0, 1));
		directed_rows.push_back(mk_row(toeq_pkg::CMD_INSERT, 0, 0, 0, 0, 1,
			toeq_pkg::ST_OK, 0, 0, 0, 0, 2));
		directed_rows.push_back(mk_row(toeq_pkg::CMD_REMOVE, 0, 0, 0, 0, 1,
			toeq_pkg::ST_OK, 0, 0, 0, 0, 1));
		directed_rows.push_back(mk_row(toeq_pkg::CMD_REMOVE, 32'h1234_5678, 16'hA5A5, 3'd5,
			2'd2, 1, toeq_pkg::ST_OK, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 2'd3, 0));
		directed_rows.push_back(mk_row(toeq_pkg::CMD_REMOVE, 0, 0, 0, 0, 1,
			toeq_pkg::ST_EMPTY, 0, 0, 0, 0, 0));
		begin
			logic [toeq_pkg::TimeW-1:0] keys[16];
			keys = '{100, 100, 50, 100, 32'hFFFF_FFFF, 0, 100, 50, 200, 100, 7,
				32'hFFFF_FFFF, 100, 0, 150, 100};
			for (int i = 0; i < 16; i++)
				directed_rows.push_back(mk_row(toeq_pkg::CMD_INSERT, keys[i], 16'(i + 1),
					3'(i), 2'(i), 0, toeq_pkg::ST_OK, 0, 0, 0, 0, 0));
		end
		directed_rows.push_back(mk_row(toeq_pkg::CMD_INSERT, 5, 16'h0F0F, 3'd1, 2'd1,
			1, toeq_pkg::ST_FULL, 0, 0, 0, 0, 16));
		directed_rows.push_back(mk_row(toeq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 3'd7,
			2'd3, 1, toeq_pkg::ST_FULL, 0, 0, 0, 0, 16));
		directed_rows.push_back(mk_row(toeq_pkg::CMD_REMOVE, 0, 0, 0, 0, 0,
			toeq_pkg::ST_OK, 0, 0, 0, 0, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			idle_gap();
			send_beat(directed_rows[i].cmd, directed_rows[i].ev, directed_rows[i].typed,
				directed_rows[i].res);
		end
		drain_pause();

		// Blocks of 50 beats lean towards filling, draining or an even mix.
		for (int n = 0; n < RandomBeats; n++) begin
			if (n % 50 == 0) begin
				case ((n / 50) % 3)
					0: ins_pct = 85;
					1: ins_pct = 15;
					default: ins_pct = 50;
				endcase
			end
			if (n == RandomBeats / 2)
				drain_pause();
			if (n == RandomBeats - CalmBeats)
				calm = 1'b1;
			c = ($urandom_range(0, 99) < ins_pct) ? toeq_pkg::CMD_INSERT
				: toeq_pkg::CMD_REMOVE;
			roll = $urandom_range(0, 9);
			if (roll < 5)
				ev.ev_time = $urandom_range(0, 15);
			else if (roll < 7)
				ev.ev_time = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			else
				ev.ev_time = $urandom();
			ev.job = $urandom_range(0, 65535);
			ev.kind = $urandom_range(0, 7);
			ev.disk = $urandom_range(0, 3);
			idle_gap();
			send_beat(c, ev, 1'b0, '0);
		end

		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d command beats: %0d events dispatched in time order,",
			beats_sent, dispatched);
		$display("%0d removes on an empty queue, %0d inserts on a full queue",
			empty_removes, full_inserts);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
